FILE: design/cau_pkg.sv
package cau_pkg;

   localparam int CAU_FRAC_BITS = 16;
   localparam int DW = 32;
   localparam int PW = 64;
   localparam int SW = PW + 1;
   localparam int QW = DW + 1;
   localparam int RW = PW + QW;

   typedef enum logic [1:0] {
      CMD_ADD,
      CMD_SUB,
      CMD_MUL,
      CMD_DIV
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_SAT,
      ST_DIV0
   } status_type;

   typedef struct packed {
      logic [DW-1:0] re;
      logic [DW-1:0] im;
      status_type    st;
   } result_type;

   typedef struct packed {
      cmd_type              cmd;
      logic signed [DW:0]   as_re;
      logic signed [DW:0]   as_im;
      logic signed [PW-1:0] p_rr;
      logic signed [PW-1:0] p_ii;
      logic signed [PW-1:0] p_ri;
      logic signed [PW-1:0] p_ir;
      logic [PW-1:0]        p_bb_r;
      logic [PW-1:0]        p_bb_i;
   } prod_type;

   typedef struct packed {
      cmd_type              cmd;
      result_type           pass;
      logic signed [SW-1:0] n_re;
      logic signed [SW-1:0] n_im;
      logic [PW-1:0]        den;
   } comb_type;

   typedef struct packed {
      cmd_type       cmd;
      result_type    pass;
      logic [RW-1:0] rem_re;
      logic [RW-1:0] rem_im;
      logic [QW-1:0] q_re;
      logic [QW-1:0] q_im;
      logic          neg_re;
      logic          neg_im;
      logic [PW-1:0] den;
      logic          zero;
   } dv_type;

   // {saturated, value}
   function automatic logic [DW:0] sat_to32(input logic [SW-1:0] v);
      logic fits;
      fits = (v[SW-1:DW-1] == '0) || (v[SW-1:DW-1] == '1);
      if (fits) begin
         return {1'b0, v[DW-1:0]};
      end
      return {1'b1, v[SW-1] ? 32'h8000_0000 : 32'h7fff_ffff};
   endfunction

endpackage

FILE: design/cau_mult.sv
module cau_mult
   import cau_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  cmd_type              cmd,
   input  logic signed [DW-1:0] a_re,
   input  logic signed [DW-1:0] a_im,
   input  logic signed [DW-1:0] b_re,
   input  logic signed [DW-1:0] b_im,
   output logic                 out_valid,
   input  logic                 out_ready,
   output prod_type             out_data
);

   logic     valid_ff;
   prod_type data_ff;
   prod_type data_in;
   logic signed [PW-1:0] bb_r;
   logic signed [PW-1:0] bb_i;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in.cmd = cmd;
      if (cmd == CMD_SUB) begin
         data_in.as_re = $signed({a_re[DW-1], a_re}) - $signed({b_re[DW-1], b_re});
         data_in.as_im = $signed({a_im[DW-1], a_im}) - $signed({b_im[DW-1], b_im});
      end else begin
         data_in.as_re = $signed({a_re[DW-1], a_re}) + $signed({b_re[DW-1], b_re});
         data_in.as_im = $signed({a_im[DW-1], a_im}) + $signed({b_im[DW-1], b_im});
      end
      data_in.p_rr   = PW'(a_re) * PW'(b_re);
      data_in.p_ii   = PW'(a_im) * PW'(b_im);
      data_in.p_ri   = PW'(a_re) * PW'(b_im);
      data_in.p_ir   = PW'(a_im) * PW'(b_re);
      bb_r           = PW'(b_re) * PW'(b_re);
      bb_i           = PW'(b_im) * PW'(b_im);
      data_in.p_bb_r = bb_r;
      data_in.p_bb_i = bb_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: design/cau_combine.sv
module cau_combine
   import cau_pkg::*;
#(
   parameter int FRAC_BITS = CAU_FRAC_BITS
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  prod_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output comb_type out_data
);

   logic     valid_ff;
   comb_type data_ff;
   comb_type data_in;
   logic signed [SW-1:0] wr;
   logic signed [SW-1:0] wi;
   logic signed [SW-1:0] wr_sh;
   logic signed [SW-1:0] wi_sh;
   logic [DW:0] sr;
   logic [DW:0] si;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      wr    = $signed({in_data.p_rr[PW-1], in_data.p_rr})
            - $signed({in_data.p_ii[PW-1], in_data.p_ii});
      wi    = $signed({in_data.p_ri[PW-1], in_data.p_ri})
            + $signed({in_data.p_ir[PW-1], in_data.p_ir});
      wr_sh = wr >>> FRAC_BITS;
      wi_sh = wi >>> FRAC_BITS;
      case (in_data.cmd)
         CMD_ADD, CMD_SUB: begin
            sr = sat_to32({{(SW-DW-1){in_data.as_re[DW]}}, in_data.as_re});
            si = sat_to32({{(SW-DW-1){in_data.as_im[DW]}}, in_data.as_im});
         end
         CMD_MUL: begin
            sr = sat_to32(wr_sh);
            si = sat_to32(wi_sh);
         end
         default: begin
            sr = '0;
            si = '0;
         end
      endcase
      data_in.cmd     = in_data.cmd;
      data_in.pass.re = sr[DW-1:0];
      data_in.pass.im = si[DW-1:0];
      data_in.pass.st = (sr[DW] || si[DW]) ? ST_SAT : ST_OK;
      data_in.n_re    = $signed({in_data.p_rr[PW-1], in_data.p_rr})
                      + $signed({in_data.p_ii[PW-1], in_data.p_ii});
      data_in.n_im    = $signed({in_data.p_ir[PW-1], in_data.p_ir})
                      - $signed({in_data.p_ri[PW-1], in_data.p_ri});
      data_in.den     = in_data.p_bb_r + in_data.p_bb_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: design/cau_divider.sv
module cau_divider
   import cau_pkg::*;
#(
   parameter int FRAC_BITS = CAU_FRAC_BITS
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  comb_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output dv_type   out_data
);

   localparam int NS = QW + 1;

   logic [NS-1:0] v_ff;
   dv_type        d_ff [NS];
   logic [NS:0]   adv;
   dv_type        first_in;
   logic [SW-1:0] m_re;
   logic [SW-1:0] m_im;

   assign adv[NS]   = out_ready;
   assign in_ready  = adv[0];
   assign out_valid = v_ff[NS-1];
   assign out_data  = d_ff[NS-1];

   // magnitudes, scaled numerators
   always_comb begin
      m_re            = in_data.n_re[SW-1] ? (SW'(0) - in_data.n_re) : in_data.n_re;
      m_im            = in_data.n_im[SW-1] ? (SW'(0) - in_data.n_im) : in_data.n_im;
      first_in.cmd    = in_data.cmd;
      first_in.pass   = in_data.pass;
      first_in.rem_re = {{(RW-PW){1'b0}}, m_re[PW-1:0]} << FRAC_BITS;
      first_in.rem_im = {{(RW-PW){1'b0}}, m_im[PW-1:0]} << FRAC_BITS;
      first_in.q_re   = '0;
      first_in.q_im   = '0;
      first_in.neg_re = in_data.n_re[SW-1];
      first_in.neg_im = in_data.n_im[SW-1];
      first_in.den    = in_data.den;
      first_in.zero   = (in_data.den == '0);
   end

   assign adv[0] = !v_ff[0] || adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv[0]) begin
         v_ff[0] <= in_valid;
      end
      if (adv[0]) begin
         d_ff[0] <= first_in;
      end
   end

   // one restoring step per stage, quotient bit QW-s
   for (genvar s = 1; s < NS; s++) begin : g_step
      dv_type        nxt;
      logic [RW-1:0] dsh;

      assign adv[s] = !v_ff[s] || adv[s+1];
      assign dsh    = {{(RW-PW){1'b0}}, d_ff[s-1].den} << (QW - s);

      always_comb begin
         nxt = d_ff[s-1];
         if (d_ff[s-1].rem_re >= dsh) begin
            nxt.rem_re        = d_ff[s-1].rem_re - dsh;
            nxt.q_re[QW - s]  = 1'b1;
         end
         if (d_ff[s-1].rem_im >= dsh) begin
            nxt.rem_im        = d_ff[s-1].rem_im - dsh;
            nxt.q_im[QW - s]  = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv[s]) begin
            v_ff[s] <= v_ff[s-1];
         end
         if (adv[s]) begin
            d_ff[s] <= nxt;
         end
      end
   end

endmodule

FILE: design/cau_finish.sv
module cau_finish
   import cau_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  dv_type     in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       valid_ff;
   result_type data_ff;
   result_type data_in;
   logic       sat_re;
   logic       sat_im;
   logic [DW-1:0] val_re;
   logic [DW-1:0] val_im;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      sat_re = in_data.q_re[DW] ||
               (in_data.neg_re ? (in_data.q_re[DW-1:0] > 32'h8000_0000) : in_data.q_re[DW-1]);
      sat_im = in_data.q_im[DW] ||
               (in_data.neg_im ? (in_data.q_im[DW-1:0] > 32'h8000_0000) : in_data.q_im[DW-1]);
      if (sat_re) begin
         val_re = in_data.neg_re ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
         val_re = in_data.neg_re ? (32'd0 - in_data.q_re[DW-1:0]) : in_data.q_re[DW-1:0];
      end
      if (sat_im) begin
         val_im = in_data.neg_im ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
         val_im = in_data.neg_im ? (32'd0 - in_data.q_im[DW-1:0]) : in_data.q_im[DW-1:0];
      end
      if (in_data.cmd != CMD_DIV) begin
         data_in = in_data.pass;
      end else if (in_data.zero) begin
         data_in.re = '0;
         data_in.im = '0;
         data_in.st = ST_DIV0;
      end else begin
         data_in.re = val_re;
         data_in.im = val_im;
         data_in.st = (sat_re || sat_im) ? ST_SAT : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: design/complex_arithmetic_unit.sv
// An accepted item passes products, sums, 34 divider stages and the
//   output register on its way to rsp_tvalid, the same for every command.
// Throughput: one item per cycle unless stalled; 33 restoring steps set depth.
// Each stage holds under backpressure, bubbles are squeezed out.
// Reset: synchronous, active high, clears the stage valid bits only.
module complex_arithmetic_unit
   import cau_pkg::*;
#(
   parameter int FRAC_BITS = CAU_FRAC_BITS
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // a_re, a_im, b_re, b_im
   input  logic [1:0]   req_tuser,  // command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,  // res_re, res_im
   output logic [1:0]   rsp_tuser   // status
);

   logic       m_valid;
   logic       m_ready;
   prod_type   m_data;
   logic       c_valid;
   logic       c_ready;
   comb_type   c_data;
   logic       d_valid;
   logic       d_ready;
   dv_type     d_data;
   result_type r_data;

   cau_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .cmd       (cmd_type'(req_tuser)),
      .a_re      ($signed(req_tdata[31:0])),
      .a_im      ($signed(req_tdata[63:32])),
      .b_re      ($signed(req_tdata[95:64])),
      .b_im      ($signed(req_tdata[127:96])),
      .out_valid (m_valid),
      .out_ready (m_ready),
      .out_data  (m_data)
   );

   cau_combine #(.FRAC_BITS(FRAC_BITS)) u_combine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m_valid),
      .in_ready  (m_ready),
      .in_data   (m_data),
      .out_valid (c_valid),
      .out_ready (c_ready),
      .out_data  (c_data)
   );

   cau_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid),
      .in_ready  (c_ready),
      .in_data   (c_data),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_data  (d_data)
   );

   cau_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .in_data   (d_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (r_data)
   );

   assign rsp_tdata = {r_data.im, r_data.re};
   assign rsp_tuser = r_data.st;

endmodule

FILE: design/cau_checker.sv
module cau_checker
   import cau_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [63:0]  rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp item dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_div0_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_DIV0 |-> rsp_tdata == 64'd0)
      else $error("divide by zero item with nonzero result");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_SAT |->
         rsp_tdata[31:0] == 32'h7fff_ffff || rsp_tdata[31:0] == 32'h8000_0000 ||
         rsp_tdata[63:32] == 32'h7fff_ffff || rsp_tdata[63:32] == 32'h8000_0000)
      else $error("saturated item without a limit value");

endmodule

bind complex_arithmetic_unit cau_checker u_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import cau_pkg::*;

   localparam int FB = CAU_FRAC_BITS;

   typedef struct {
      cmd_type     cmd;
      logic [31:0] a_re, a_im, b_re, b_im;
   } op_item;

   typedef struct {
      logic [31:0] re, im;
      status_type  st;
   } cplx_result;

   typedef struct {
      op_item     op;
      bit         known;
      cplx_result res;
   } dir_row;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [63:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   cplx_result expected_q[$];
   int errors = 0;
   int n_items = 0;
   int n_results = 0;
   int n_sat = 0;
   int n_div0 = 0;
   bit rx_on = 0;

   complex_arithmetic_unit u_top (.*);

   always #5 clock = ~clock;

   function automatic logic [31:0] clamp32(input logic signed [127:0] v, ref bit sat);
      if (v > 128'sd2147483647) begin
         sat = 1;
         return 32'h7fff_ffff;
      end
      if (v < -128'sd2147483648) begin
         sat = 1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // numerator << FB / den, truncated toward zero
   function automatic logic [31:0] quot_part(input logic signed [127:0] num,
                                             input logic signed [127:0] den, ref bit sat);
      logic signed [127:0] q;
      q = (num <<< FB) / den;
      return clamp32(q, sat);
   endfunction

   function automatic cplx_result predict_cplx(input op_item op);
      logic signed [127:0] ar, ai, br, bi, d, x, y;
      cplx_result r;
      bit sat;
      sat = 0;
      ar = $signed(op.a_re);
      ai = $signed(op.a_im);
      br = $signed(op.b_re);
      bi = $signed(op.b_im);
      case (op.cmd)
         CMD_ADD: begin
            r.re = clamp32(ar + br, sat);
            r.im = clamp32(ai + bi, sat);
         end
         CMD_SUB: begin
            r.re = clamp32(ar - br, sat);
            r.im = clamp32(ai - bi, sat);
         end
         CMD_MUL: begin
            x = ar * br - ai * bi;
            y = ar * bi + ai * br;
            r.re = clamp32(x >>> FB, sat);
            r.im = clamp32(y >>> FB, sat);
         end
         default: begin
            d = br * br + bi * bi;
            if (d == 0) begin
               r.re = '0;
               r.im = '0;
               r.st = ST_DIV0;
               return r;
            end
            r.re = quot_part(ar * br + ai * bi, d, sat);
            r.im = quot_part(ai * br - ar * bi, d, sat);
         end
      endcase
      r.st = sat ? ST_SAT : ST_OK;
      return r;
   endfunction

   function automatic logic [31:0] rand_part();
      case ($urandom_range(0, 5))
         0: return 32'h7fff_ffff - $urandom_range(0, 3);
         1: return 32'h8000_0000 + $urandom_range(0, 3);
         2: return $urandom_range(0, 1) ? 32'h0 : 32'h1_0000;
         3: return {{16{1'b0}}, 16'($urandom)} ^ ($urandom_range(0, 1) ? '1 : '0);
         4: return {{8{1'b0}}, 24'($urandom)} ^ ($urandom_range(0, 1) ? '1 : '0);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(input op_item op, input bit known, input cplx_result res);
      cplx_result r;
      r = known ? res : predict_cplx(op);
      req_tvalid <= 1;
      req_tdata <= {op.b_im, op.b_re, op.a_im, op.a_re};
      req_tuser <= op.cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_q.push_back(r);
      n_items++;
   endtask

   always @(posedge clock) begin
      cplx_result e;
      if (rsp_tvalid && rsp_tready) begin
         n_results++;
         if (expected_q.size() == 0) begin
            $error("unexpected item: re=%h im=%h st=%0d", rsp_tdata[31:0],
                   rsp_tdata[63:32], rsp_tuser);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (e.st == ST_SAT) n_sat++;
            if (e.st == ST_DIV0) n_div0++;
            if (rsp_tdata[31:0] !== e.re) begin
               $error("res_re expected %h actual %h", e.re, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[63:32] !== e.im) begin
               $error("res_im expected %h actual %h", e.im, rsp_tdata[63:32]);
               errors++;
            end
            if (rsp_tuser !== e.st) begin
               $error("status expected %0d actual %0d", e.st, rsp_tuser);
               errors++;
            end
         end
      end
   end

   // receiver: random mix of ready and stall
   always @(posedge clock) begin
      int run;
      if (!rx_on) begin
         rsp_tready <= 0;
      end else begin
         run = $urandom_range(0, 7);
         case (run)
            0, 1: rsp_tready <= 0;
            2: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= 1;
         endcase
      end
   end

   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      dir_row rows[$];
      op_item op;
      cplx_result none;
      int burst, k, waits;
      none = '{re: '0, im: '0, st: ST_OK};
      rows = '{
         '{'{CMD_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'hffff_ffff}, 1,
           '{32'h7fff_ffff, 32'h8000_0000, ST_SAT}},
         '{'{CMD_ADD, 32'h1, 32'h2, 32'h3, 32'h4}, 1, '{32'h4, 32'h6, ST_OK}},
         '{'{CMD_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'hffff_ffff}, 1,
           '{32'h8000_0000, 32'h7fff_ffff, ST_SAT}},
         '{'{CMD_SUB, 32'h5, 32'h0, 32'h5, 32'h0}, 1, '{32'h0, 32'h0, ST_OK}},
         '{'{CMD_MUL, 32'h1_0000, 32'h0, 32'h0, 32'h1_0000}, 1,
           '{32'h0, 32'h1_0000, ST_OK}},
         '{'{CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1,
           '{32'h0, 32'h7fff_ffff, ST_SAT}},
         '{'{CMD_MUL, 32'hffff_ffff, 32'h0, 32'h1, 32'h0}, 1,
           '{32'hffff_ffff, 32'h0, ST_OK}},
         '{'{CMD_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000}, 0, none},
         '{'{CMD_DIV, 32'h1234_5678, 32'h8000_0000, 32'h0, 32'h0}, 1,
           '{32'h0, 32'h0, ST_DIV0}},
         '{'{CMD_DIV, 32'h1_0000, 32'h0, 32'h1_0000, 32'h0}, 1,
           '{32'h1_0000, 32'h0, ST_OK}},
         '{'{CMD_DIV, 32'h7fff_ffff, 32'h0, 32'h1, 32'h0}, 1,
           '{32'h7fff_ffff, 32'h0, ST_SAT}},
         '{'{CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'h1, 32'h1}, 0, none},
         '{'{CMD_DIV, 32'hffff_ffff, 32'h0, 32'h3_0000, 32'h0}, 0, none},
         '{'{CMD_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000}, 0, none},
         '{'{CMD_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h1}, 0, none},
         '{'{CMD_MUL, 32'h8000_0000, 32'h0, 32'h1_0000, 32'h0}, 0, none}
      };
      repeat (6) @(posedge clock);
      reset <= 0;
      rx_on <= 1;
      foreach (rows[i]) send_item(rows[i].op, rows[i].known, rows[i].res);
      for (int i = 0; i < 700; ) begin
         burst = $urandom_range(1, 30);
         for (k = 0; k < burst && i < 700; k++, i++) begin
            op.cmd = cmd_type'($urandom_range(0, 3));
            op.a_re = rand_part();
            op.a_im = rand_part();
            op.b_re = rand_part();
            op.b_im = rand_part();
            if (op.cmd == CMD_DIV && $urandom_range(0, 15) == 0) begin
               op.b_re = '0;
               op.b_im = '0;
            end
            send_item(op, 0, none);
         end
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
      req_tvalid <= 0;
      waits = 0;
      while (expected_q.size() != 0 && waits < 200000) begin
         @(posedge clock);
         waits++;
      end
      repeat (60) @(posedge clock);
      $display("Covered %0d items, %0d results (%0d saturated, %0d divide by zero).",
               n_items, n_results, n_sat, n_div0);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
design/cau_pkg.sv
design/cau_mult.sv
design/cau_combine.sv
design/cau_divider.sv
design/cau_finish.sv
design/complex_arithmetic_unit.sv
design/cau_checker.sv
tb/tb.sv
